### sv/gas_sensor_ppm_linearizer_macros.svh
// ----------------------------------------------------------------------------
// gas_sensor_ppm_linearizer_macros
// assertion helpers used by the linearizer back end
// ----------------------------------------------------------------------------
`ifndef GAS_SENSOR_PPM_LINEARIZER_MACROS_SVH
`define GAS_SENSOR_PPM_LINEARIZER_MACROS_SVH

// assert that an antecedent implies a consequent in the same cycle
`define GPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// assert that an antecedent implies a consequent in the next cycle
`define GPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/gpl_pkg.sv
// ----------------------------------------------------------------------------
// gpl_pkg
// shared types, constants and tables for the ppm linearizer
// ----------------------------------------------------------------------------
package gpl_pkg;

    localparam int ADC_WIDTH_DEF = 12;
    localparam int K_WIDTH = 24;
    localparam int QDEPTH = 4;

    localparam logic [1:0] REG_K = 2'd0;
    localparam logic [1:0] REG_REF = 2'd1;
    localparam logic [1:0] REG_VALID = 2'd2;

    localparam logic [17:0] EXP_COEF = 18'd251199;
    localparam logic signed [63:0] LOG2_C_Q32 = -64'sd194218 * 64'sd65536;

    // front to back queue entry
    typedef struct packed {
        logic [31:0] q;
        logic bad;
    } gpl_item_t;

    function automatic logic [16:0] log2_lut(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0: r = 17'd0;
            5'd1: r = 17'd5732;
            5'd2: r = 17'd11136;
            5'd3: r = 17'd16248;
            5'd4: r = 17'd21098;
            5'd5: r = 17'd25711;
            5'd6: r = 17'd30109;
            5'd7: r = 17'd34312;
            5'd8: r = 17'd38336;
            5'd9: r = 17'd42196;
            5'd10: r = 17'd45904;
            5'd11: r = 17'd49472;
            5'd12: r = 17'd52911;
            5'd13: r = 17'd56229;
            5'd14: r = 17'd59434;
            5'd15: r = 17'd62534;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    function automatic logic [17:0] exp2_lut(input logic [4:0] i);
        logic [17:0] r;
        case (i)
            5'd0: r = 18'd65536;
            5'd1: r = 18'd68438;
            5'd2: r = 18'd71468;
            5'd3: r = 18'd74632;
            5'd4: r = 18'd77936;
            5'd5: r = 18'd81386;
            5'd6: r = 18'd84990;
            5'd7: r = 18'd88753;
            5'd8: r = 18'd92682;
            5'd9: r = 18'd96785;
            5'd10: r = 18'd101070;
            5'd11: r = 18'd105545;
            5'd12: r = 18'd110218;
            5'd13: r = 18'd115098;
            5'd14: r = 18'd120194;
            5'd15: r = 18'd125515;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

endpackage

### sv/gpl_divider.sv
// ----------------------------------------------------------------------------
// gpl_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module gpl_divider
    import gpl_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 40,
    parameter int TW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag,
    output logic          out_vld,
    output logic [NW-1:0] quo,
    output logic [TW-1:0] out_tag
);
    logic [NW-1:0] n_reg [NW+1];
    logic [NW-1:0] q_reg [NW+1];
    logic [DW:0]   r_reg [NW+1];
    logic [DW-1:0] d_reg [NW+1];
    logic [TW-1:0] t_reg [NW+1];
    logic          v_reg [NW+1];

    always_comb
    begin
        n_reg[0] = num;
        q_reg[0] = '0;
        r_reg[0] = '0;
        d_reg[0] = den;
        t_reg[0] = tag;
        v_reg[0] = in_vld;
    end

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [DW+1:0] sh;
        logic [DW+1:0] df;
        assign sh = {r_reg[s], n_reg[s][NW-1-s]};
        assign df = sh - {2'b00, d_reg[s]};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (en)
                v_reg[s+1] <= v_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s+1] <= n_reg[s];
                d_reg[s+1] <= d_reg[s];
                t_reg[s+1] <= t_reg[s];
                if (!df[DW+1])
                begin
                    r_reg[s+1] <= df[DW:0];
                    q_reg[s+1] <= q_reg[s] | (NW'(1) << (NW-1-s));
                end
                else
                begin
                    r_reg[s+1] <= sh[DW:0];
                    q_reg[s+1] <= q_reg[s];
                end
            end
        end
    end

    assign out_vld = v_reg[NW];
    assign quo = q_reg[NW];
    assign out_tag = t_reg[NW];
endmodule

### sv/gpl_front.sv
// ----------------------------------------------------------------------------
// gpl_front
// classifies samples, forms the ratio and pushes it to the queue
// ----------------------------------------------------------------------------
module gpl_front
    import gpl_pkg::*;
#(
    parameter int ADC_WIDTH = ADC_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [ADC_WIDTH-1:0] m,
    input  logic [ADC_WIDTH-1:0] ref_code,
    input  logic [K_WIDTH-1:0]   k,
    input  logic                 ref_ok,
    output logic                 out_vld,
    output gpl_item_t            item
);
    localparam int SW = ADC_WIDTH + 8;
    localparam int DW = ADC_WIDTH + K_WIDTH;
    localparam int NW = DW + 16;

    logic [SW-1:0] ms, rs;
    logic          bad;
    logic [K_WIDTH-1:0] dk_m, dk_r;
    logic          v1_reg;
    logic          bad1_reg;
    logic [ADC_WIDTH-1:0] m1_reg, r1_reg;
    logic [K_WIDTH-1:0] dm1_reg, dr1_reg;
    logic [NW-1:0] num;
    logic [DW-1:0] den;
    logic [NW-1:0] quo;
    logic          dv;
    logic          dbad;

    assign ms = {m, 8'd0};
    assign rs = {ref_code, 8'd0};
    assign bad = (m == '0) || (ref_code == '0) || !ref_ok
              || ({{(K_WIDTH+8){1'b0}}, ms} >= (SW+K_WIDTH+8)'(k))
              || ({{(K_WIDTH+8){1'b0}}, rs} >= (SW+K_WIDTH+8)'(k));
    assign dk_m = k - K_WIDTH'(ms);
    assign dk_r = k - K_WIDTH'(rs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bad1_reg <= bad;
            m1_reg <= m;
            r1_reg <= ref_code;
            dm1_reg <= dk_m;
            dr1_reg <= dk_r;
        end
    end

    assign num = {DW'(r1_reg) * DW'(dm1_reg), 16'd0};
    // error items get a unit divisor so the divider never sees zero
    assign den = bad1_reg ? DW'(1) : DW'(m1_reg) * DW'(dr1_reg);

    gpl_divider #(.NW(NW), .DW(DW), .TW(1)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v1_reg),
        .num(num), .den(den), .tag(bad1_reg),
        .out_vld(dv), .quo(quo), .out_tag(dbad)
    );

    assign out_vld = dv;
    assign item.bad = dbad;
    assign item.q = (quo[NW-1:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
endmodule

### sv/gpl_back.sv
// ----------------------------------------------------------------------------
// gpl_back
// log2, power law scaling and exp2 of the ratio, with output register
// ----------------------------------------------------------------------------
module gpl_back
    import gpl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_vld,
    output logic            in_stall,
    input  gpl_item_t       item,
    output logic            out_vld,
    input  logic            out_stall,
    output logic [15:0]     ppm,
    output logic            flag
);
    `include "gas_sensor_ppm_linearizer_macros.svh"

    logic en;
    // stage 1: leading one and table lookup
    logic [4:0]  e;
    logic [31:0] mant;
    logic        v1_reg, sat1_reg, bad1_reg;
    logic [4:0]  e1_reg;
    logic [16:0] lo1_reg, hi1_reg;
    logic [15:0] rem1_reg;
    // stage 2: log value
    logic        v2_reg, sat2_reg, bad2_reg;
    logic signed [21:0] lg2_reg;
    logic [32:0] pr1;
    // stage 3: y
    logic        v3_reg, bad3_reg;
    logic [1:0]  cls3_reg;
    logic [63:0] u3_reg;
    logic signed [63:0] y;
    // stage 4: exp table
    logic        v4_reg, bad4_reg;
    logic [1:0]  cls4_reg;
    logic [4:0]  ip4_reg;
    logic [17:0] lo4_reg, hi4_reg;
    logic [15:0] rem4_reg;
    logic [33:0] pr2;
    logic [17:0] mnt;
    logic [50:0] vsh;
    logic [32:0] vr;
    logic [15:0] res;
    logic        ov_reg;
    logic [15:0] ppm_reg;
    logic        flag_reg;

    localparam logic [1:0] CLS_NORM = 2'd0;
    localparam logic [1:0] CLS_MAX = 2'd1;
    localparam logic [1:0] CLS_ZERO = 2'd2;

    assign en = !ov_reg || !out_stall;
    assign in_stall = !en;

    always_comb
    begin
        e = '0;
        for (int i = 0; i < 32; i++)
            if (item.q[i])
                e = 5'(i);
    end
    assign mant = item.q << (5'd31 - e);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld; v2_reg <= v1_reg; v3_reg <= v2_reg;
            v4_reg <= v3_reg; ov_reg <= v4_reg;
        end
    end

    assign pr1 = (hi1_reg - lo1_reg) * rem1_reg;
    assign y = LOG2_C_Q32 - 64'(signed'({1'b0, EXP_COEF})) * 64'(lg2_reg);
    assign pr2 = (hi4_reg - lo4_reg) * rem4_reg;
    assign mnt = lo4_reg + 18'(pr2 >> 16);
    assign vsh = 51'(mnt) << ip4_reg;
    assign vr = 33'((vsh + 51'(1 << 17)) >> 18);
    assign res = (vr > 33'd65535) ? 16'hFFFF : vr[15:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat1_reg <= (item.q == '0);
            bad1_reg <= item.bad;
            e1_reg <= e;
            lo1_reg <= log2_lut({1'b0, mant[30:27]});
            hi1_reg <= log2_lut(5'({1'b0, mant[30:27]}) + 5'd1);
            rem1_reg <= mant[26:11];

            sat2_reg <= sat1_reg;
            bad2_reg <= bad1_reg;
            lg2_reg <= 22'(signed'({1'b0, e1_reg}) - 6'sd16) * 22'sd65536
                     + 22'(lo1_reg + 17'(pr1 >> 16));

            bad3_reg <= bad2_reg;
            if (sat2_reg || y >= 64'sd16 * 64'sh1_0000_0000)
                cls3_reg <= CLS_MAX;
            else if (y < -64'sd2 * 64'sh1_0000_0000)
                cls3_reg <= CLS_ZERO;
            else
                cls3_reg <= CLS_NORM;
            u3_reg <= 64'(y + 64'sd2 * 64'sh1_0000_0000);

            bad4_reg <= bad3_reg;
            cls4_reg <= cls3_reg;
            ip4_reg <= u3_reg[36:32];
            lo4_reg <= exp2_lut({1'b0, u3_reg[31:28]});
            hi4_reg <= exp2_lut(5'({1'b0, u3_reg[31:28]}) + 5'd1);
            rem4_reg <= u3_reg[27:12];

            flag_reg <= bad4_reg;
            if (bad4_reg || cls4_reg == CLS_MAX)
                ppm_reg <= 16'hFFFF;
            else if (cls4_reg == CLS_ZERO)
                ppm_reg <= 16'd0;
            else
                ppm_reg <= res;
        end
    end

    assign out_vld = ov_reg;
    assign ppm = ppm_reg;
    assign flag = flag_reg;

    `GPL_ASSERT_NEXT(a_hold, clk, rst_n, ov_reg && out_stall, ov_reg && $stable(ppm_reg), "held result changed")
    `GPL_ASSERT_IMP(a_flag_max, clk, rst_n, ov_reg && flag_reg, ppm_reg == 16'hFFFF, "error item not saturated")
    `GPL_ASSERT_IMP(a_stall, clk, rst_n, in_stall, ov_reg && out_stall, "back stalls without cause")
endmodule

### sv/gpl_queue.sv
// ----------------------------------------------------------------------------
// gpl_queue
// small fifo between front and back, with an occupancy count that stalls the front
// ----------------------------------------------------------------------------
module gpl_queue
    import gpl_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  gpl_item_t wdata,
    input  logic      pop,
    output logic      not_empty,
    output gpl_item_t rdata,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int AW = $clog2(DEPTH);
    gpl_item_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end

    assign rdata = mem[rp_reg];
    assign not_empty = cnt_reg != '0;
    assign count = cnt_reg;
endmodule

### sv/gas_sensor_ppm_linearizer.sv
// front: 1 input stage and ADC_WIDTH+K_WIDTH+16 divider stages; queue: 1; back: 5
// throughput: one sample per cycle while stall is low, every stage is pipelined
// stalls: back holds on out_stall; front freezes and stall rises while the queue is full
// reset: rst_n asynchronous active low clears valids, queue pointers and settings
// ----------------------------------------------------------------------------
// gas_sensor_ppm_linearizer
// ADC code to ppm conversion, decoupled front and back with a queue
// ----------------------------------------------------------------------------
module gas_sensor_ppm_linearizer
    import gpl_pkg::*;
#(
    parameter int ADC_WIDTH = ADC_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 stall,
    input  logic [ADC_WIDTH-1:0] sample_code,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [15:0]          ppm_value,
    output logic                 invalid_flag,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [K_WIDTH-1:0]   cfg_data
);
    localparam int DEPTH = QDEPTH;

    logic [K_WIDTH-1:0]   k_reg;
    logic [ADC_WIDTH-1:0] ref_reg;
    logic                 rv_reg;
    logic                 fv;
    gpl_item_t            fitem, qitem;
    logic                 qne, bstall;
    logic [$clog2(DEPTH+1)-1:0] qcnt;
    logic                 fen;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0; ref_reg <= '0; rv_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_K: k_reg <= cfg_data;
                REG_REF: ref_reg <= cfg_data[ADC_WIDTH-1:0];
                REG_VALID: rv_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // whole front pipeline freezes while the queue is full
    assign fen = qcnt != ($clog2(DEPTH+1))'(DEPTH);
    assign stall = !fen;

    gpl_front #(.ADC_WIDTH(ADC_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .en(fen), .in_vld(valid && !stall),
        .m(sample_code), .ref_code(ref_reg), .k(k_reg), .ref_ok(rv_reg),
        .out_vld(fv), .item(fitem)
    );

    gpl_queue #(.DEPTH(DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(fv && fen), .wdata(fitem),
        .pop(qne && !bstall), .not_empty(qne), .rdata(qitem), .count(qcnt)
    );

    gpl_back u_back (
        .clk(clk), .rst_n(rst_n), .in_vld(qne), .in_stall(bstall), .item(qitem),
        .out_vld(out_valid), .out_stall(out_stall),
        .ppm(ppm_value), .flag(invalid_flag)
    );
endmodule
